[src/lec_pkg.sv]
// ----------------------------------------------------------------------------
// lec_pkg: shared types and constants of the line ending converter
// Request layouts, line break codes, style codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lec_pkg;

  // Default counter width
  localparam int unsigned COUNT_WIDTH = 32;

  // Width of the count fields in a result
  localparam int unsigned OUT_CNT_WIDTH = 32;

  // Line break characters
  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  // Configuration register indexes
  localparam logic CFG_TARGET_STYLE = 1'b0;
  localparam logic CFG_EMIT_ENABLE  = 1'b1;

  // Raw target style codes (code three behaves as LF)
  localparam logic [1:0] STYLE_LF   = 2'd0;
  localparam logic [1:0] STYLE_CRLF = 2'd1;
  localparam logic [1:0] STYLE_CR   = 2'd2;

  // Unpaired break left behind by the previous byte
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_CR   = 2'd1,
    PEND_LF   = 2'd2
  } pend_e;

  // Input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
    logic       start_of_block;
  } lec_in_t;

  // Result request
  typedef struct packed {
    logic [7:0]               out_byte;
    logic                     byte_valid;
    logic                     last_of_run;
    logic [OUT_CNT_WIDTH-1:0] break_count;
    logic [OUT_CNT_WIDTH-1:0] mismatch_count;
    logic [OUT_CNT_WIDTH-1:0] needed_size;
    logic                     saw_zero_byte;
  } lec_out_t;

endpackage

`default_nettype wire

[src/lec_step.sv]
// ----------------------------------------------------------------------------
// lec_step: per-byte conversion and counting
// Combinational step from one registered input request and the current state
// to the next state and up to two result requests.
// ----------------------------------------------------------------------------
`default_nettype none

module lec_step
  import lec_pkg::*;
#(
  parameter int unsigned CountWidth = COUNT_WIDTH
) (
  input  lec_in_t               req_i,
  input  logic [1:0]            target_style_i,
  input  logic                  emit_enable_i,
  input  pend_e                 pend_i,
  input  logic [CountWidth-1:0] brk_i,
  input  logic [CountWidth-1:0] mis_i,
  input  logic [CountWidth-1:0] plain_i,
  input  logic [CountWidth-1:0] sum1_i,
  input  logic [CountWidth-1:0] sum2_i,
  input  logic                  zero_i,
  output pend_e                 pend_o,
  output logic [CountWidth-1:0] brk_o,
  output logic [CountWidth-1:0] mis_o,
  output logic [CountWidth-1:0] plain_o,
  output logic [CountWidth-1:0] sum1_o,
  output logic [CountWidth-1:0] sum2_o,
  output logic                  zero_o,
  output lec_out_t              res0_o,
  output lec_out_t              res1_o,
  output logic                  two_o
);

  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [CountWidth-1:0] CountOne = CountWidth'(1);
  localparam logic [CountWidth-1:0] CountTwo = CountWidth'(2);

  logic                  is_cr, is_lf, is_brk, absorbed, counted, mismatch;
  logic                  clear_cnt;
  logic [1:0]            style;
  pend_e                 pend_base;
  logic [CountWidth-1:0] brk_b, mis_b, plain_b, sum1_b, sum2_b, needed;
  logic                  zero_b;
  logic [7:0]            first_byte;
  logic [OUT_CNT_WIDTH-1:0] brk_w, mis_w, need_w;

  // Effective style: the unused code falls back to LF
  always_comb begin
    case (target_style_i)
      STYLE_CRLF: style = STYLE_CRLF;
      STYLE_CR:   style = STYLE_CR;
      default:    style = STYLE_LF;
    endcase
  end

  // Start flags act before the byte
  assign clear_cnt = req_i.start_of_file | req_i.start_of_block;
  assign pend_base = req_i.start_of_file ? PEND_NONE : pend_i;
  assign brk_b     = clear_cnt ? '0 : brk_i;
  assign mis_b     = clear_cnt ? '0 : mis_i;
  assign plain_b   = clear_cnt ? '0 : plain_i;
  assign sum1_b    = clear_cnt ? '0 : sum1_i;
  assign sum2_b    = clear_cnt ? '0 : sum2_i;
  assign zero_b    = clear_cnt ? 1'b0 : zero_i;

  // Classify the byte
  assign is_cr    = (req_i.in_byte == BYTE_CR);
  assign is_lf    = (req_i.in_byte == BYTE_LF);
  assign is_brk   = is_cr | is_lf;
  assign absorbed = (is_cr && pend_base == PEND_LF) || (is_lf && pend_base == PEND_CR);
  assign counted  = is_brk & ~absorbed;
  assign mismatch = counted & (is_cr ? (style == STYLE_LF) : (style != STYLE_LF));

  // Saturating counters; sum1 tracks plain+break, sum2 tracks plain+2*break
  always_comb begin
    brk_o   = brk_b;
    mis_o   = mis_b;
    plain_o = plain_b;
    sum1_o  = sum1_b;
    sum2_o  = sum2_b;
    if (counted) begin
      if (brk_b != CountMax) brk_o = brk_b + CountOne;
    end
    if (mismatch) begin
      if (mis_b != CountMax) mis_o = mis_b + CountOne;
    end
    if (!is_brk) begin
      if (plain_b != CountMax) plain_o = plain_b + CountOne;
    end
    if (counted || !is_brk) begin
      if (sum1_b != CountMax) sum1_o = sum1_b + CountOne;
    end
    if (!is_brk) begin
      if (sum2_b != CountMax) sum2_o = sum2_b + CountOne;
    end else if (counted) begin
      sum2_o = (sum2_b >= CountMax - CountOne) ? CountMax : sum2_b + CountTwo;
    end
  end

  assign zero_o = zero_b | (req_i.in_byte == 8'd0);
  assign pend_o = counted ? (is_cr ? PEND_CR : PEND_LF) : PEND_NONE;
  assign needed = (style == STYLE_CRLF) ? sum2_o : sum1_o;

  // Results show the low bits of the counters, zero-extended when the counters are narrower
  if (CountWidth >= OUT_CNT_WIDTH) begin : g_trunc
    assign brk_w  = brk_o[OUT_CNT_WIDTH-1:0];
    assign mis_w  = mis_o[OUT_CNT_WIDTH-1:0];
    assign need_w = needed[OUT_CNT_WIDTH-1:0];
  end else begin : g_ext
    assign brk_w  = {{(OUT_CNT_WIDTH-CountWidth){1'b0}}, brk_o};
    assign mis_w  = {{(OUT_CNT_WIDTH-CountWidth){1'b0}}, mis_o};
    assign need_w = {{(OUT_CNT_WIDTH-CountWidth){1'b0}}, needed};
  end

  // First emitted byte
  always_comb begin
    if (!is_brk) begin
      first_byte = req_i.in_byte;
    end else if (style == STYLE_LF) begin
      first_byte = BYTE_LF;
    end else begin
      first_byte = BYTE_CR;
    end
  end

  // Result assembly
  always_comb begin
    res0_o.break_count    = brk_w;
    res0_o.mismatch_count = mis_w;
    res0_o.needed_size    = need_w;
    res0_o.saw_zero_byte  = zero_o;
    res1_o.break_count    = brk_w;
    res1_o.mismatch_count = mis_w;
    res1_o.needed_size    = need_w;
    res1_o.saw_zero_byte  = zero_o;
    res1_o.out_byte       = BYTE_LF;
    res1_o.byte_valid     = 1'b1;
    res1_o.last_of_run    = 1'b1;
    if (!emit_enable_i || absorbed) begin
      two_o              = 1'b0;
      res0_o.out_byte    = 8'd0;
      res0_o.byte_valid  = 1'b0;
      res0_o.last_of_run = 1'b1;
    end else begin
      two_o              = counted && (style == STYLE_CRLF);
      res0_o.out_byte    = first_byte;
      res0_o.byte_valid  = 1'b1;
      res0_o.last_of_run = ~two_o;
    end
  end

endmodule

`default_nettype wire

[src/line_ending_converter_core.sv]
// ----------------------------------------------------------------------------
// line_ending_converter_core: line break style converter with block counters
// Rewrites CR, LF and CR-LF breaks of a byte stream into the target style and
// keeps saturating per-block counts of breaks, mismatches and output size.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------
//  input    | in        | in_valid_i / in_stall_o| in_req_i  (lec_in_t)
//  result   | out       | out_valid_o/out_stall_i| out_res_o (lec_out_t)
//  config   | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Each byte goes input register -> step logic -> result register. A byte
// gives one result and a CR-LF break two, so the result port sets the
// rate.
// Reset clears the state, the counters and the valid flags; no clearing pass.
// A stalled result holds; the input register keeps taking requests while a
// finished result waits, and stalls only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module line_ending_converter_core
  import lec_pkg::*;
#(
  parameter int unsigned CountWidth = COUNT_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lec_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lec_out_t out_res_o,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [1:0] cfg_data_i
);

  logic [1:0] style_q;
  logic       emit_q;

  logic     in_valid_q;
  lec_in_t  in_q;
  logic     out_valid_q, pend2_q;
  lec_out_t out_q, out2_q;

  pend_e                 pend_q, pend_d;
  logic [CountWidth-1:0] brk_q, brk_d, mis_q, mis_d, plain_q, plain_d;
  logic [CountWidth-1:0] sum1_q, sum1_d, sum2_q, sum2_d;
  logic                  zero_q, zero_d;

  lec_out_t res0, res1;
  logic     two;
  logic     out_take, out_done, move, in_take;

  // Handshake
  assign out_take   = out_valid_q & ~out_stall_i;
  assign out_done   = out_take & ~pend2_q;
  assign move       = in_valid_q & (~out_valid_q | out_done);
  assign in_stall_o = in_valid_q & ~move;
  assign in_take    = in_valid_i & ~in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= STYLE_LF;
      emit_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_STYLE: style_q <= cfg_data_i;
        CFG_EMIT_ENABLE:  emit_q  <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Conversion step
  lec_step #(
    .CountWidth(CountWidth)
  ) u_step (
    .req_i          (in_q),
    .target_style_i (style_q),
    .emit_enable_i  (emit_q),
    .pend_i         (pend_q),
    .brk_i          (brk_q),
    .mis_i          (mis_q),
    .plain_i        (plain_q),
    .sum1_i         (sum1_q),
    .sum2_i         (sum2_q),
    .zero_i         (zero_q),
    .pend_o         (pend_d),
    .brk_o          (brk_d),
    .mis_o          (mis_d),
    .plain_o        (plain_d),
    .sum1_o         (sum1_d),
    .sum2_o         (sum2_d),
    .zero_o         (zero_d),
    .res0_o         (res0),
    .res1_o         (res1),
    .two_o          (two)
  );

  // Block state, updated as a byte leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PEND_NONE;
      brk_q   <= '0;
      mis_q   <= '0;
      plain_q <= '0;
      sum1_q  <= '0;
      sum2_q  <= '0;
      zero_q  <= 1'b0;
    end else if (move) begin
      pend_q  <= pend_d;
      brk_q   <= brk_d;
      mis_q   <= mis_d;
      plain_q <= plain_d;
      sum1_q  <= sum1_d;
      sum2_q  <= sum2_d;
      zero_q  <= zero_d;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend2_q     <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
        pend2_q     <= two;
      end else if (out_take && pend2_q) begin
        pend2_q <= 1'b0;
      end else if (out_done) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
    if (move) begin
      out_q  <= res0;
      out2_q <= res1;
    end else if (out_take && pend2_q) begin
      out_q <= out2_q;
    end
  end

endmodule

`default_nettype wire

[src/lec_checker.sv]
// ----------------------------------------------------------------------------
// lec_checker: port-level checks of the line ending converter
// Checks stall hold, result ordering of break pairs and the form of empty results.
// ----------------------------------------------------------------------------
`default_nettype none

module lec_checker
  import lec_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input lec_out_t out_res_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // The first half of a pair is always a CR
  a_first_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.last_of_run |->
      out_res_o.byte_valid && out_res_o.out_byte == BYTE_CR)
    else $error("non-final result is not a CR");

  // The second half follows at once: an LF that closes the run
  a_second_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_res_o.last_of_run |=>
      out_valid_o && out_res_o.last_of_run && out_res_o.out_byte == BYTE_LF)
    else $error("CR of a pair not followed by its LF");

  // An empty result carries a zero byte and closes its run
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.byte_valid |->
      out_res_o.out_byte == 8'd0 && out_res_o.last_of_run)
    else $error("malformed empty result");

endmodule

bind line_ending_converter_core lec_checker u_lec_checker (.*);

`default_nettype wire
